/* rtl/pmvc_pkg.sv */
`default_nettype none

package pmvc_pkg;

  localparam int MAX_VERTICES_DEF   = 4096;
  localparam int MAX_PARTITIONS_DEF = 8;
  localparam int ELEMENT_BYTES_DEF  = 4;

  localparam int KIND_W  = 2;
  localparam int VID_W   = 12;
  localparam int PART_W  = 8;
  localparam int TOTAL_W = 16;
  localparam int VSEEN_W = 13;
  localparam int GBYTE_W = 41;
  localparam int LBYTE_W = 35;

  localparam int PCNT_W = 4;
  localparam int LCNT_W = 7;
  localparam int HID_W  = 16;
  localparam int FEAT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET    = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_REPORT = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARTITION_COUNT = 2'd0,
    CFG_LAYER_COUNT     = 2'd1,
    CFG_HIDDEN_UNITS    = 2'd2,
    CFG_FEATURE_WIDTH   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PCNT_W-1:0] partition_count;
    logic [LCNT_W-1:0] layer_count;
    logic [HID_W-1:0]  hidden_units;
    logic [FEAT_W-1:0] feature_width;
  } cfg_t;

  typedef struct packed {
    logic set_part;
    logic take_edge;
    logic clear;
  } store_cmd_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] mirror_total;
    logic [VSEEN_W-1:0] vertex_limit;
  } counts_t;

endpackage

`default_nettype wire

/* rtl/pmvc_if.sv */
`default_nettype none

interface pmvc_in_if;
  logic                             valid;
  logic                             ready;
  logic [pmvc_pkg::KIND_W-1:0]      kind;
  logic [pmvc_pkg::VID_W-1:0]       vertex_id;
  logic [pmvc_pkg::PART_W-1:0]      part_value;
  logic [pmvc_pkg::VID_W-1:0]       edge_source;
  logic [pmvc_pkg::VID_W-1:0]       edge_target;

  modport source (
    output valid, kind, vertex_id, part_value, edge_source, edge_target,
    input  ready
  );
  modport sink (
    input  valid, kind, vertex_id, part_value, edge_source, edge_target,
    output ready
  );
endinterface

interface pmvc_out_if;
  logic                             valid;
  logic                             ready;
  logic [pmvc_pkg::TOTAL_W-1:0]     mirror_total_out;
  logic [pmvc_pkg::VSEEN_W-1:0]     vertices_seen;
  logic [pmvc_pkg::GBYTE_W-1:0]     graph_level_bytes;
  logic [pmvc_pkg::LBYTE_W-1:0]     layer_level_bytes;

  modport source (
    output valid, mirror_total_out, vertices_seen, graph_level_bytes, layer_level_bytes,
    input  ready
  );
  modport sink (
    input  valid, mirror_total_out, vertices_seen, graph_level_bytes, layer_level_bytes,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/pmvc_store.sv */
`default_nettype none

module pmvc_store #(
  parameter int MAX_VERTICES   = pmvc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_PARTITIONS = pmvc_pkg::MAX_PARTITIONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pmvc_pkg::store_cmd_t           cmd,
  input  wire logic [pmvc_pkg::VID_W-1:0]     vertex_id,
  input  wire logic [pmvc_pkg::PART_W-1:0]    part_value,
  input  wire logic [pmvc_pkg::VID_W-1:0]     edge_source,
  input  wire logic [pmvc_pkg::VID_W-1:0]     edge_target,
  input  wire logic [pmvc_pkg::PCNT_W-1:0]    partition_count,
  output logic                                idle,
  output pmvc_pkg::counts_t                   counts
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int MP = MAX_PARTITIONS;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EDGE  = 3'b010,
    ST_CLEAR = 3'b100
  } st_t;

  logic [pmvc_pkg::PART_W-1:0] ptab [MAX_VERTICES];
  logic [MP-1:0]               mmap [MAX_VERTICES];

  st_t                           state_r;
  logic [VW-1:0]                 clr_cnt_r;
  logic [pmvc_pkg::PART_W-1:0]   ps_r;
  logic [pmvc_pkg::PART_W-1:0]   pd_r;
  logic [MP-1:0]                 map_r;
  logic [VW-1:0]                 dst_r;
  logic [pmvc_pkg::TOTAL_W-1:0]  total_r;
  logic [pmvc_pkg::VSEEN_W-1:0]  limit_r;

  logic                          vid_ok, src_ok, dst_ok;
  logic                          set_go, edge_go;
  logic [VW-1:0]                 vid_a, src_a, dst_a;
  logic [pmvc_pkg::VID_W-1:0]    hi_id;
  logic [pmvc_pkg::VSEEN_W-1:0]  lim;
  logic                          hit, new_mark;
  logic [PW-1:0]                 bitsel;
  logic                          map_we;
  logic [VW-1:0]                 map_addr;
  logic [MP-1:0]                 map_wdata;

  always_comb begin
    vid_ok  = 32'(vertex_id) < 32'(MAX_VERTICES);
    src_ok  = 32'(edge_source) < 32'(MAX_VERTICES);
    dst_ok  = 32'(edge_target) < 32'(MAX_VERTICES);
    set_go  = cmd.set_part && vid_ok;
    edge_go = cmd.take_edge && src_ok && dst_ok;
    vid_a   = VW'(vertex_id);
    src_a   = VW'(edge_source);
    dst_a   = VW'(edge_target);
    hi_id   = (edge_source > edge_target) ? edge_source : edge_target;
    lim     = pmvc_pkg::VSEEN_W'(hi_id) + pmvc_pkg::VSEEN_W'(1);

    bitsel   = ps_r[PW-1:0];
    hit      = (ps_r < pmvc_pkg::PART_W'(partition_count)) &&
               (32'(ps_r) < 32'(MAX_PARTITIONS)) && (ps_r != pd_r);
    new_mark = hit && !map_r[bitsel];

    map_we    = 1'b0;
    map_addr  = dst_r;
    map_wdata = map_r | (MP'(1) << bitsel);
    priority if (state_r == ST_CLEAR) begin
      map_we    = 1'b1;
      map_addr  = clr_cnt_r;
      map_wdata = '0;
    end else if (state_r == ST_EDGE) begin
      map_we = new_mark;
    end
  end

  // memories: registered reads
  always_ff @(posedge clk) begin
    if (set_go) begin
      ptab[vid_a] <= part_value;
    end
    if (edge_go) begin
      ps_r  <= ptab[src_a];
      pd_r  <= ptab[dst_a];
      map_r <= mmap[dst_a];
      dst_r <= dst_a;
    end
    if (map_we) begin
      mmap[map_addr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      total_r   <= '0;
      limit_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.clear) begin
            state_r   <= ST_CLEAR;
            clr_cnt_r <= '0;
            total_r   <= '0;
            limit_r   <= '0;
          end else if (edge_go) begin
            state_r <= ST_EDGE;
            if (lim > limit_r) begin
              limit_r <= lim;
            end
          end
        end
        ST_EDGE: begin
          if (new_mark && (total_r != '1)) begin
            total_r <= total_r + pmvc_pkg::TOTAL_W'(1);
          end
          state_r <= ST_IDLE;
        end
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + VW'(1);
          if (clr_cnt_r == VW'(MAX_VERTICES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign idle                = (state_r == ST_IDLE);
  assign counts.mirror_total = total_r;
  assign counts.vertex_limit = limit_r;

endmodule

`default_nettype wire

/* rtl/pmvc_volume.sv */
`default_nettype none

module pmvc_volume #(
  parameter int ELEMENT_BYTES = pmvc_pkg::ELEMENT_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire pmvc_pkg::cfg_t    cfg,
  input  wire pmvc_pkg::counts_t counts,
  output logic                   idle,
  pmvc_out_if.source             out_req
);

  localparam int KW   = $clog2(2 * ELEMENT_BYTES + 1);
  localparam int KMTW = pmvc_pkg::TOTAL_W + KW;
  localparam int AW   = pmvc_pkg::HID_W + pmvc_pkg::LCNT_W;
  localparam int CW   = AW + 1;
  localparam int BW   = pmvc_pkg::PCNT_W + pmvc_pkg::VSEEN_W;
  localparam int EW   = BW + pmvc_pkg::HID_W;
  localparam int GPW  = KMTW + CW;
  localparam int LPW  = EW + KW;
  localparam logic [KW-1:0] BYTE_K = KW'(2 * ELEMENT_BYTES);

  typedef enum logic [2:0] {
    V_IDLE = 3'b001,
    V_MUL  = 3'b010,
    V_OUT  = 3'b100
  } vst_t;

  vst_t                         st_r;
  logic [AW-1:0]                a_r;
  logic [BW-1:0]                b_r;
  logic [KMTW-1:0]              kmt_r;
  logic [CW-1:0]                c_r;
  logic [EW-1:0]                e_r;
  logic                         valid_r;
  logic [pmvc_pkg::TOTAL_W-1:0] total_out_r;
  logic [pmvc_pkg::VSEEN_W-1:0] vseen_r;
  logic [pmvc_pkg::GBYTE_W-1:0] graph_r;
  logic [pmvc_pkg::LBYTE_W-1:0] layer_r;

  logic [pmvc_pkg::LCNT_W-1:0]  lcm1;
  logic [pmvc_pkg::PCNT_W-1:0]  pcm1;
  logic [GPW-1:0]               gprod;
  logic [LPW-1:0]               lprod;
  logic                         load;

  always_comb begin
    lcm1  = (cfg.layer_count == '0) ? '0 : cfg.layer_count - pmvc_pkg::LCNT_W'(1);
    pcm1  = (cfg.partition_count == '0) ? '0
                                        : cfg.partition_count - pmvc_pkg::PCNT_W'(1);
    gprod = GPW'(kmt_r) * GPW'(c_r);
    lprod = LPW'(e_r) * LPW'(BYTE_K);
    load  = (st_r == V_OUT) && (!valid_r || out_req.ready);
  end

  // counts stay put until load: input is held off while busy
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= AW'(cfg.hidden_units) * AW'(lcm1);
      b_r   <= BW'(pcm1) * BW'(counts.vertex_limit);
      kmt_r <= KMTW'(counts.mirror_total) * KMTW'(BYTE_K);
    end
    if (st_r == V_MUL) begin
      c_r <= CW'(cfg.feature_width) + CW'(a_r);
      e_r <= EW'(b_r) * EW'(cfg.hidden_units);
    end
    if (load) begin
      total_out_r <= counts.mirror_total;
      vseen_r     <= counts.vertex_limit;
      graph_r     <= gprod[pmvc_pkg::GBYTE_W-1:0];
      layer_r     <= lprod[pmvc_pkg::LBYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= V_IDLE;
      valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        V_IDLE:  if (start) st_r <= V_MUL;
        V_MUL:   st_r <= V_OUT;
        V_OUT:   if (load) st_r <= V_IDLE;
        default: st_r <= V_IDLE;
      endcase
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_req.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign idle                      = (st_r == V_IDLE);
  assign out_req.valid             = valid_r;
  assign out_req.mirror_total_out  = total_out_r;
  assign out_req.vertices_seen     = vseen_r;
  assign out_req.graph_level_bytes = graph_r;
  assign out_req.layer_level_bytes = layer_r;

endmodule

`default_nettype wire

/* rtl/partition_mirror_vertex_counter_core.sv */
// Set-partition request: one table write. Edge request: table read, then bitmap write-back.
// Report request: V_MUL, then V_OUT, to a valid result, held in an output register while later
// requests proceed; a further report waits while that register is still full.
// Clear request: one bitmap entry zeroed per cycle until all MAX_VERTICES entries are zeroed.
// Reset (synchronous, active low) clears control and counts, sets configuration to defaults, then
// sweeps all MAX_VERTICES bitmap entries before in_req.ready rises; configuration writes go on.
`default_nettype none

module partition_mirror_vertex_counter_core #(
  parameter int MAX_VERTICES   = pmvc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_PARTITIONS = pmvc_pkg::MAX_PARTITIONS_DEF,
  parameter int ELEMENT_BYTES  = pmvc_pkg::ELEMENT_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  pmvc_in_if.sink                                 in_req,
  pmvc_out_if.source                              out_req,
  input  wire logic                               cfg_we,
  input  wire logic [pmvc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pmvc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  pmvc_pkg::cfg_t       cfg_r;
  pmvc_pkg::store_cmd_t cmd;
  pmvc_pkg::counts_t    counts;
  logic                 store_idle;
  logic                 vol_idle;
  logic                 accept;
  logic                 report_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.partition_count <= pmvc_pkg::PCNT_W'(2);
      cfg_r.layer_count     <= pmvc_pkg::LCNT_W'(2);
      cfg_r.hidden_units    <= pmvc_pkg::HID_W'(16);
      cfg_r.feature_width   <= pmvc_pkg::FEAT_W'(16);
    end else if (cfg_we) begin
      unique case (pmvc_pkg::cfg_reg_t'(cfg_index))
        pmvc_pkg::CFG_PARTITION_COUNT:
          cfg_r.partition_count <= cfg_wdata[pmvc_pkg::PCNT_W-1:0];
        pmvc_pkg::CFG_LAYER_COUNT:
          cfg_r.layer_count <= cfg_wdata[pmvc_pkg::LCNT_W-1:0];
        pmvc_pkg::CFG_HIDDEN_UNITS:
          cfg_r.hidden_units <= cfg_wdata[pmvc_pkg::HID_W-1:0];
        pmvc_pkg::CFG_FEATURE_WIDTH:
          cfg_r.feature_width <= cfg_wdata[pmvc_pkg::FEAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_req.ready  = store_idle && vol_idle;
  assign accept        = in_req.valid && in_req.ready;
  assign cmd.set_part  = accept && (in_req.kind == pmvc_pkg::KIND_SET);
  assign cmd.take_edge = accept && (in_req.kind == pmvc_pkg::KIND_EDGE);
  assign cmd.clear     = accept && (in_req.kind == pmvc_pkg::KIND_CLEAR);
  assign report_go     = accept && (in_req.kind == pmvc_pkg::KIND_REPORT);

  pmvc_store #(
    .MAX_VERTICES   (MAX_VERTICES),
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_store (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .vertex_id       (in_req.vertex_id),
    .part_value      (in_req.part_value),
    .edge_source     (in_req.edge_source),
    .edge_target     (in_req.edge_target),
    .partition_count (cfg_r.partition_count),
    .idle            (store_idle),
    .counts          (counts)
  );

  pmvc_volume #(
    .ELEMENT_BYTES (ELEMENT_BYTES)
  ) u_volume (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (report_go),
    .cfg     (cfg_r),
    .counts  (counts),
    .idle    (vol_idle),
    .out_req (out_req)
  );

endmodule

`default_nettype wire
